// ===== design/mvdi_pkg.sv =====
// Shared constants, types and the key hash of the mesh vertex dedup indexer.
`default_nettype none
package mvdi_pkg;

   // Table geometry.
   localparam int MAX_VERTICES = 4096;
   localparam int VTX_BITS     = 12;
   localparam int CNT_BITS     = 13;
   localparam int INDEX_BITS   = 21;
   localparam int KEY_BITS     = 3 * INDEX_BITS;
   localparam int NUM_BITS     = 22;
   localparam int SLOT_BITS    = 13;
   localparam int SLOTS        = 1 << SLOT_BITS;
   localparam int KEY_ENTRY_BITS = KEY_BITS + SLOT_BITS;

   localparam logic [CNT_BITS-1:0]   CNT_MAX     = CNT_BITS'(MAX_VERTICES);
   localparam logic [NUM_BITS-1:0]   COUNT_LIMIT = NUM_BITS'(1) << INDEX_BITS;
   localparam logic [INDEX_BITS-1:0] FIELD_ONES  = '1;

   // Operation codes.
   localparam logic [1:0] OP_CORNER = 2'd0;
   localparam logic [1:0] OP_GROUP  = 2'd1;
   localparam logic [1:0] OP_ATTR   = 2'd2;

   // Attribute kinds.
   localparam logic [1:0] ATTR_POS    = 2'd0;
   localparam logic [1:0] ATTR_UV     = 2'd1;
   localparam logic [1:0] ATTR_NORMAL = 2'd2;

   // Result record kinds.
   localparam logic [1:0] REC_INDEX = 2'd0;
   localparam logic [1:0] REC_NEW   = 2'd1;
   localparam logic [1:0] REC_FULL  = 2'd2;

   // Corner emission order; a triangle uses the first three entries.
   localparam logic [1:0] CORNER_ORDER [6] = '{2'd2, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3};

   // Answer of the lookup engine.
   typedef struct packed {
      logic                done;
      logic                found;
      logic                is_new;
      logic                full;
      logic [VTX_BITS-1:0] index;
   } probe_rsp_type;

   // Work handed to the output sequencer for one input beat.
   typedef struct packed {
      logic                       rec_valid;
      logic [1:0]                 rec_kind;
      logic [VTX_BITS-1:0]        rec_vertex;
      logic [INDEX_BITS-1:0]      rec_pos;
      logic [INDEX_BITS-1:0]      rec_uv;
      logic [INDEX_BITS-1:0]      rec_normal;
      logic [2:0]                 idx_cnt;
      logic [3:0][VTX_BITS-1:0]   corner;
   } emit_job_type;

   // Home slot of a key {uv, normal, position}: rotate and fold.
   function automatic logic [SLOT_BITS-1:0] hash_slot(input logic [KEY_BITS-1:0] key);
      logic [INDEX_BITS-1:0] p;
      logic [INDEX_BITS-1:0] n;
      logic [INDEX_BITS-1:0] u;
      logic [INDEX_BITS-1:0] x;
      p = key[INDEX_BITS-1:0];
      n = key[2*INDEX_BITS-1:INDEX_BITS];
      u = key[3*INDEX_BITS-1:2*INDEX_BITS];
      x = p ^ {n[10:0], n[20:11]} ^ {u[5:0], u[20:6]};
      return x[SLOT_BITS-1:0] ^ {5'd0, x[20:13]};
   endfunction

endpackage
`default_nettype wire

// ===== design/mesh_vertex_dedup_indexer.sv =====
// Top level of the mesh vertex dedup indexer: decode, corner checks and face state.
//
// A face corner is checked against the declared attribute counts, packed into a
// key and looked up in a hash slot table (8192 slots) that points into a dense key
// store of 4096 entries; both are memories with one write port, one read port and
// registered read data. A corner first reads its home slot; when the slot holds a
// live index, the key store entry is read and compared. A corner whose key is found
// goes back to idle, or through the handoff state when it hands results to the
// output sequencer. A new vertex on an empty home slot is inserted right after the
// slot read. Every further probe of the linear chain adds one slot read and one key
// read. Attribute, group and bad corner beats are handled without leaving idle.
// Results leave one per cycle through an output register while rsp_tready is high.
// A corner with results waits in its handoff state while the sequencer still
// streams an earlier job; otherwise the next beat is taken while earlier results
// are still leaving. After reset all 8192 slots of the slot table are swept, and
// req_tready stays low during the sweep.
`default_nettype none
module mesh_vertex_dedup_indexer
   import mvdi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] operation, [3:2] attr_kind
   input  wire logic [3:0]  req_tuser,
   // [1:0] corner_slot, [4:2] corner_total, [26:5] pos_number, [27] uv_present,
   // [49:28] uv_number, [50] normal_present, [72:51] normal_number
   input  wire logic [79:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [11:0] vertex_index, [32:12] pos_index, [53:33] uv_index, [74:54] normal_index
   output logic [79:0]      rsp_tdata,
   // [1:0] record_kind
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast
);

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_LOOK = 2'd1;
   localparam logic [1:0] T_HAND = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic [NUM_BITS-1:0]        pos_cnt_ff, pos_cnt_in;
   logic [NUM_BITS-1:0]        uv_cnt_ff, uv_cnt_in;
   logic [NUM_BITS-1:0]        nrm_cnt_ff, nrm_cnt_in;
   logic [3:0][VTX_BITS-1:0]   corner_ff, corner_in;
   logic                       face_bad_ff, face_bad_in;
   logic [1:0]                 slot_ff, slot_in;
   logic                       quad_ff, quad_in;
   logic                       final_ff, final_in;
   logic [KEY_BITS-1:0]        key_ff, key_in;
   emit_job_type               job_ff, job_in;

   logic [1:0]            op, attr_kind, c_slot;
   logic [2:0]            c_total;
   logic [NUM_BITS-1:0]   pos_num, uv_num, nrm_num;
   logic                  uv_pres, nrm_pres;
   logic                  shape_ok, corner_ok, accept;
   logic [INDEX_BITS-1:0] p_idx, u_idx, n_idx;
   logic [KEY_BITS-1:0]   key_now;
   logic                  probe_ready, probe_start, probe_clear;
   probe_rsp_type         probe_rsp;
   logic                  emit_busy, emit_load;
   logic                  fb_after;
   logic [3:0][VTX_BITS-1:0] corner_upd;

   // Field unpacking.
   assign op        = req_tuser[1:0];
   assign attr_kind = req_tuser[3:2];
   assign c_slot    = req_tdata[1:0];
   assign c_total   = req_tdata[4:2];
   assign pos_num   = req_tdata[26:5];
   assign uv_pres   = req_tdata[27];
   assign uv_num    = req_tdata[49:28];
   assign nrm_pres  = req_tdata[50];
   assign nrm_num   = req_tdata[72:51];

   // Corner checks and key packing.
   assign shape_ok  = (c_total == 3'd3 || c_total == 3'd4) && ({1'b0, c_slot} < c_total);
   assign corner_ok = shape_ok && pos_num != '0 && pos_num <= pos_cnt_ff
                      && (!uv_pres || (uv_num != '0 && uv_num <= uv_cnt_ff))
                      && (!nrm_pres || (nrm_num != '0 && nrm_num <= nrm_cnt_ff));
   assign p_idx   = INDEX_BITS'(pos_num - 1'b1);
   assign u_idx   = uv_pres ? INDEX_BITS'(uv_num - 1'b1) : FIELD_ONES;
   assign n_idx   = nrm_pres ? INDEX_BITS'(nrm_num - 1'b1) : FIELD_ONES;
   assign key_now = {u_idx, n_idx, p_idx};

   assign req_tready  = (state_ff == T_IDLE) && probe_ready;
   assign accept      = req_tvalid && req_tready;
   assign probe_start = accept && op == OP_CORNER && corner_ok;
   assign probe_clear = accept && op == OP_GROUP;
   assign emit_load   = (state_ff == T_HAND);

   mvdi_probe u_probe (
      .clock (clock),
      .reset (reset),
      .clear (probe_clear),
      .start (probe_start),
      .key   (key_now),
      .ready (probe_ready),
      .rsp   (probe_rsp)
   );

   mvdi_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (emit_load),
      .job        (job_ff),
      .busy       (emit_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Beat decode, lookup completion and job handoff.
   always_comb begin
      state_in    = state_ff;
      pos_cnt_in  = pos_cnt_ff;
      uv_cnt_in   = uv_cnt_ff;
      nrm_cnt_in  = nrm_cnt_ff;
      corner_in   = corner_ff;
      face_bad_in = face_bad_ff;
      slot_in     = slot_ff;
      quad_in     = quad_ff;
      final_in    = final_ff;
      key_in      = key_ff;
      job_in      = job_ff;
      fb_after    = face_bad_ff | probe_rsp.full;
      corner_upd  = corner_ff;
      corner_upd[slot_ff] = probe_rsp.index;
      unique case (state_ff)
         T_IDLE: begin
            if (accept) begin
               unique case (op)
                  OP_GROUP: begin
                     face_bad_in = 1'b1;
                  end
                  OP_ATTR: begin
                     if (attr_kind == ATTR_POS && pos_cnt_ff < COUNT_LIMIT) begin
                        pos_cnt_in = pos_cnt_ff + 1'b1;
                     end
                     if (attr_kind == ATTR_UV && uv_cnt_ff < COUNT_LIMIT) begin
                        uv_cnt_in = uv_cnt_ff + 1'b1;
                     end
                     if (attr_kind == ATTR_NORMAL && nrm_cnt_ff < COUNT_LIMIT) begin
                        nrm_cnt_in = nrm_cnt_ff + 1'b1;
                     end
                  end
                  OP_CORNER: begin
                     if (!corner_ok) begin
                        face_bad_in = 1'b1;
                     end else begin
                        if (c_slot == 2'd0) begin
                           face_bad_in = 1'b0;
                        end
                        slot_in  = c_slot;
                        quad_in  = (c_total == 3'd4);
                        final_in = ({1'b0, c_slot} == c_total - 3'd1);
                        key_in   = key_now;
                        state_in = T_LOOK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         T_LOOK: begin
            if (probe_rsp.done) begin
               face_bad_in = fb_after;
               if (!probe_rsp.full) begin
                  corner_in = corner_upd;
               end
               job_in.rec_valid  = probe_rsp.is_new | probe_rsp.full;
               job_in.rec_kind   = probe_rsp.is_new ? REC_NEW : REC_FULL;
               job_in.rec_vertex = probe_rsp.is_new ? probe_rsp.index : '0;
               job_in.rec_pos    = probe_rsp.is_new ? key_ff[INDEX_BITS-1:0] : '0;
               job_in.rec_normal = probe_rsp.is_new ?
                                   key_ff[2*INDEX_BITS-1:INDEX_BITS] : '0;
               job_in.rec_uv     = probe_rsp.is_new ?
                                   key_ff[3*INDEX_BITS-1:2*INDEX_BITS] : '0;
               job_in.idx_cnt    = (final_ff && !fb_after) ?
                                   (quad_ff ? 3'd6 : 3'd3) : 3'd0;
               job_in.corner     = corner_upd;
               if (probe_rsp.is_new || probe_rsp.full || (final_ff && !fb_after)) begin
                  state_in = T_HAND;
               end else begin
                  state_in = T_IDLE;
               end
            end
         end
         T_HAND: begin
            if (!emit_busy) begin
               state_in = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= T_IDLE;
         pos_cnt_ff  <= '0;
         uv_cnt_ff   <= '0;
         nrm_cnt_ff  <= '0;
         corner_ff   <= '0;
         face_bad_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pos_cnt_ff  <= pos_cnt_in;
         uv_cnt_ff   <= uv_cnt_in;
         nrm_cnt_ff  <= nrm_cnt_in;
         corner_ff   <= corner_in;
         face_bad_ff <= face_bad_in;
      end
      slot_ff  <= slot_in;
      quad_ff  <= quad_in;
      final_ff <= final_in;
      key_ff   <= key_in;
      job_ff   <= job_in;
   end

endmodule
`default_nettype wire

// ===== design/mvdi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mvdi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== design/mvdi_probe.sv =====
// Key lookup engine: open-addressed slot table over a dense key store.
`default_nettype none
module mvdi_probe
   import mvdi_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                clear,
   input  wire logic                start,
   input  wire logic [KEY_BITS-1:0] key,
   output logic                     ready,
   output probe_rsp_type            rsp
);

   localparam logic [1:0] P_CLEAR = 2'd0;
   localparam logic [1:0] P_IDLE  = 2'd1;
   localparam logic [1:0] P_HWAIT = 2'd2;
   localparam logic [1:0] P_KWAIT = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [SLOT_BITS-1:0] clr_ff, clr_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [VTX_BITS-1:0]  idx_ff, idx_in;

   logic                      h_wr_en, h_rd_en;
   logic [SLOT_BITS-1:0]      h_wr_addr, h_rd_addr;
   logic [CNT_BITS-1:0]       h_wr_data, h_rd_data;
   logic                      k_wr_en, k_rd_en;
   logic [VTX_BITS-1:0]       k_wr_addr, k_rd_addr;
   logic [KEY_ENTRY_BITS-1:0] k_wr_data, k_rd_data;

   logic [SLOT_BITS-1:0] back_slot;
   logic [KEY_BITS-1:0]  stored_key;
   logic                 miss;

   assign back_slot  = k_rd_data[KEY_ENTRY_BITS-1:KEY_BITS];
   assign stored_key = k_rd_data[KEY_BITS-1:0];
   assign ready      = (state_ff == P_IDLE);

   // Slot table: holds a dense index; a slot is live only when the index is below
   // the count and the key store entry points back at this slot.
   mvdi_ram #(.WIDTH(CNT_BITS), .DEPTH(SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (h_wr_addr),
      .wr_data (h_wr_data),
      .rd_en   (h_rd_en),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd_data)
   );

   // Key store: {slot that points at the entry, key} by dense index.
   mvdi_ram #(.WIDTH(KEY_ENTRY_BITS), .DEPTH(MAX_VERTICES)) u_key_ram (
      .clock   (clock),
      .wr_en   (k_wr_en),
      .wr_addr (k_wr_addr),
      .wr_data (k_wr_data),
      .rd_en   (k_rd_en),
      .rd_addr (k_rd_addr),
      .rd_data (k_rd_data)
   );

   // Probe sequencer.
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      slot_in   = slot_ff;
      key_in    = key_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      h_wr_en   = 1'b0;
      h_wr_addr = slot_ff;
      h_wr_data = count_ff;
      h_rd_en   = 1'b0;
      h_rd_addr = slot_ff;
      k_wr_en   = 1'b0;
      k_wr_addr = count_ff[VTX_BITS-1:0];
      k_wr_data = {slot_ff, key_ff};
      k_rd_en   = 1'b0;
      k_rd_addr = h_rd_data[VTX_BITS-1:0];
      miss      = 1'b0;
      rsp       = '0;
      unique case (state_ff)
         P_CLEAR: begin
            h_wr_en   = 1'b1;
            h_wr_addr = clr_ff;
            h_wr_data = CNT_MAX;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == {SLOT_BITS{1'b1}}) begin
               state_in = P_IDLE;
            end
         end
         P_IDLE: begin
            if (clear) begin
               count_in = '0;
            end
            if (start) begin
               key_in    = key;
               slot_in   = hash_slot(key);
               h_rd_en   = 1'b1;
               h_rd_addr = hash_slot(key);
               state_in  = P_HWAIT;
            end
         end
         P_HWAIT: begin
            if (h_rd_data < count_ff) begin
               k_rd_en  = 1'b1;
               idx_in   = h_rd_data[VTX_BITS-1:0];
               state_in = P_KWAIT;
            end else begin
               miss = 1'b1;
            end
         end
         P_KWAIT: begin
            if (back_slot == slot_ff && stored_key == key_ff) begin
               rsp.done  = 1'b1;
               rsp.found = 1'b1;
               rsp.index = idx_ff;
               state_in  = P_IDLE;
            end else if (back_slot == slot_ff) begin
               slot_in   = slot_ff + 1'b1;
               h_rd_en   = 1'b1;
               h_rd_addr = slot_ff + 1'b1;
               state_in  = P_HWAIT;
            end else begin
               miss = 1'b1;
            end
         end
         default: begin
            state_in = P_IDLE;
         end
      endcase

      // Empty slot reached: insert, or report a full table.
      if (miss) begin
         rsp.done = 1'b1;
         state_in = P_IDLE;
         if (count_ff == CNT_MAX) begin
            rsp.full = 1'b1;
         end else begin
            h_wr_en    = 1'b1;
            k_wr_en    = 1'b1;
            count_in   = count_ff + 1'b1;
            rsp.is_new = 1'b1;
            rsp.index  = count_ff[VTX_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_CLEAR;
         clr_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         count_ff <= count_in;
      end
      slot_ff <= slot_in;
      key_ff  <= key_in;
      idx_ff  <= idx_in;
   end

endmodule
`default_nettype wire

// ===== design/mvdi_emit.sv =====
// Output sequencer: streams the record and corner indices of one input beat.
`default_nettype none
module mvdi_emit
   import mvdi_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load,
   input  wire emit_job_type  job,
   output logic               busy,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [79:0]        rsp_tdata,
   output logic [1:0]         rsp_tuser,
   output logic               rsp_tlast
);

   emit_job_type job_ff, job_in;
   logic         active_ff, active_in;
   logic         rec_done_ff, rec_done_in;
   logic [2:0]   step_ff, step_in;
   logic         valid_ff, valid_in;
   logic [79:0]  data_ff, data_in;
   logic [1:0]   user_ff, user_in;
   logic         last_ff, last_in;
   logic         can_load;

   assign can_load   = !valid_ff || rsp_tready;
   assign busy       = active_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   // Load the output register with the next result beat.
   always_comb begin
      job_in      = job_ff;
      active_in   = active_ff;
      rec_done_in = rec_done_ff;
      step_in     = step_ff;
      valid_in    = valid_ff;
      data_in     = data_ff;
      user_in     = user_ff;
      last_in     = last_ff;
      if (can_load) begin
         valid_in = 1'b0;
      end
      if (active_ff && can_load) begin
         valid_in = 1'b1;
         if (!rec_done_ff) begin
            data_in = {5'd0, job_ff.rec_normal, job_ff.rec_uv, job_ff.rec_pos,
                       job_ff.rec_vertex};
            user_in     = job_ff.rec_kind;
            last_in     = (job_ff.idx_cnt == 3'd0);
            rec_done_in = 1'b1;
            active_in   = (job_ff.idx_cnt != 3'd0);
         end else begin
            data_in   = {68'd0, job_ff.corner[CORNER_ORDER[step_ff]]};
            user_in   = REC_INDEX;
            last_in   = (step_ff == job_ff.idx_cnt - 3'd1);
            step_in   = step_ff + 3'd1;
            active_in = (step_ff != job_ff.idx_cnt - 3'd1);
         end
      end
      if (load && !active_ff) begin
         job_in      = job;
         active_in   = 1'b1;
         rec_done_in = !job.rec_valid;
         step_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
      job_ff      <= job_in;
      rec_done_ff <= rec_done_in;
      step_ff     <= step_in;
      data_ff     <= data_in;
      user_ff     <= user_in;
      last_ff     <= last_in;
   end

endmodule
`default_nettype wire

// ===== design/mvdi_checker.sv =====
// Port-level checker for the mesh vertex dedup indexer and its bind.
`default_nettype none
module mvdi_checker
   import mvdi_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [79:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tlast
);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
      && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // The slot table sweep keeps the input closed right after reset.
   a_sweep: assert property (@(posedge clock) reset |=> !req_tready && !rsp_tvalid)
      else $error("block active during the slot table sweep");

   // A table full record carries zeros and ends its face.
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == REC_FULL |-> rsp_tlast && rsp_tdata == '0)
      else $error("malformed table full record");

   // Index beats carry only a vertex index.
   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == REC_INDEX |-> rsp_tdata[79:VTX_BITS] == '0)
      else $error("index beat with stray fields");

endmodule

bind mesh_vertex_dedup_indexer mvdi_checker u_mvdi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench of the mesh vertex dedup indexer: directed and random beats.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import mvdi_pkg::*;

   localparam int RUN_LIMIT = 1000000;

   // One result record as it leaves the block.
   typedef struct packed {
      logic [1:0]            kind;
      logic [VTX_BITS-1:0]   vertex;
      logic [INDEX_BITS-1:0] pos;
      logic [INDEX_BITS-1:0] uv;
      logic [INDEX_BITS-1:0] normal;
      logic                  last;
   } vertex_rec_type;

   // Dedup predictor and the queue of records it expects.
   class dedup_board;
      logic [KEY_BITS-1:0]   key_store [MAX_VERTICES];
      int                    unique_count;
      logic [VTX_BITS-1:0]   corner_vertex [4];
      bit                    face_bad;
      logic [NUM_BITS-1:0]   pos_count, uv_count, normal_count;
      vertex_rec_type        expected_recs [$];
      int                    checked, full_seen;

      function new();
         unique_count = 0;
         face_bad = 0;
         pos_count = '0;
         uv_count = '0;
         normal_count = '0;
         checked = 0;
         full_seen = 0;
         foreach (corner_vertex[i]) corner_vertex[i] = '0;
      endfunction

      function bit number_ok(logic [NUM_BITS-1:0] num, logic [NUM_BITS-1:0] count);
         return num >= 1 && num <= count;
      endfunction

      function logic [NUM_BITS-1:0] bump(logic [NUM_BITS-1:0] c);
         return (c < COUNT_LIMIT) ? c + 1'b1 : COUNT_LIMIT;
      endfunction

      function void add_rec(logic [1:0] kind, logic [VTX_BITS-1:0] vtx,
                            logic [INDEX_BITS-1:0] p, logic [INDEX_BITS-1:0] u,
                            logic [INDEX_BITS-1:0] n);
         vertex_rec_type r;
         r = '{kind, vtx, p, u, n, 1'b0};
         expected_recs.insert(expected_recs.size(), r);
      endfunction

      // Works out the records caused by one accepted input beat.
      function void note_beat(logic [3:0] user, logic [79:0] data);
         logic [1:0]            op, attr;
         logic [1:0]            slot;
         logic [2:0]            total;
         logic [NUM_BITS-1:0]   pn, un, nn;
         logic                  up, np;
         bit                    shape_ok, ok, found;
         logic [INDEX_BITS-1:0] p, u, n;
         logic [KEY_BITS-1:0]   key;
         int                    vtx, first, cnt;
         op = user[1:0];
         attr = user[3:2];
         slot = data[1:0];
         total = data[4:2];
         pn = data[26:5];
         up = data[27];
         un = data[49:28];
         np = data[50];
         nn = data[72:51];
         first = expected_recs.size();
         if (op == OP_GROUP) begin
            unique_count = 0;
            face_bad = 1;
         end else if (op == OP_ATTR) begin
            if (attr == ATTR_POS) pos_count = bump(pos_count);
            else if (attr == ATTR_UV) uv_count = bump(uv_count);
            else if (attr == ATTR_NORMAL) normal_count = bump(normal_count);
         end else if (op == OP_CORNER) begin
            shape_ok = (total == 3 || total == 4) && slot < total;
            if (slot == 0) face_bad = 0;
            ok = shape_ok && number_ok(pn, pos_count) && (!up || number_ok(un, uv_count))
                 && (!np || number_ok(nn, normal_count));
            if (!ok) begin
               face_bad = 1;
            end else begin
               p = INDEX_BITS'(pn - 1);
               u = up ? INDEX_BITS'(un - 1) : FIELD_ONES;
               n = np ? INDEX_BITS'(nn - 1) : FIELD_ONES;
               key = {u, n, p};
               found = 0;
               vtx = 0;
               for (int i = 0; i < unique_count; i++) begin
                  if (key_store[i] == key) begin
                     found = 1;
                     vtx = i;
                     break;
                  end
               end
               if (!found) begin
                  if (unique_count >= MAX_VERTICES) begin
                     add_rec(REC_FULL, '0, '0, '0, '0);
                     face_bad = 1;
                  end else begin
                     vtx = unique_count;
                     key_store[vtx] = key;
                     unique_count++;
                     add_rec(REC_NEW, VTX_BITS'(vtx), p, u, n);
                     found = 1;
                  end
               end
               if (found) corner_vertex[slot] = VTX_BITS'(vtx);
            end
            // Last corner of a clean face sends its indices.
            if (shape_ok && slot == total - 1 && !face_bad) begin
               cnt = (total == 3) ? 3 : 6;
               for (int j = 0; j < cnt; j++)
                  add_rec(REC_INDEX, corner_vertex[CORNER_ORDER[j]], '0, '0, '0);
            end
         end
         if (expected_recs.size() > first)
            expected_recs[expected_recs.size()-1].last = 1'b1;
      endfunction

      // Compares a result with the oldest expectation; empty string when it matches.
      function string check_result(vertex_rec_type got);
         vertex_rec_type want;
         string          msg;
         if (expected_recs.size() == 0)
            return $sformatf("result with nothing expected: kind %0d vertex %0d",
                             got.kind, got.vertex);
         want = expected_recs.pop_front();
         checked++;
         if (got.kind == REC_FULL) full_seen++;
         msg = "";
         if (got.kind != want.kind)
            msg = {msg, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
         if (got.vertex != want.vertex)
            msg = {msg, $sformatf(" vertex %0d/%0d", got.vertex, want.vertex)};
         if (got.pos != want.pos)
            msg = {msg, $sformatf(" pos %0h/%0h", got.pos, want.pos)};
         if (got.uv != want.uv)
            msg = {msg, $sformatf(" uv %0h/%0h", got.uv, want.uv)};
         if (got.normal != want.normal)
            msg = {msg, $sformatf(" normal %0h/%0h", got.normal, want.normal)};
         if (got.last != want.last)
            msg = {msg, $sformatf(" last %0d/%0d", got.last, want.last)};
         if (msg != "") msg = {"mismatch (got/expected):", msg};
         return msg;
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [3:0]  req_tuser = '0;
   logic [79:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   dedup_board  board = new();
   int          mismatches = 0;
   int          beats_sent = 0;
   int          cycle_count = 0;
   int          send_idle = 0;
   int          stall_pct = 0;
   logic        hold_go = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;

   mesh_vertex_dedup_indexer u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   task report(input string msg);
      $display("[%0d] ERROR: %s", cycle_count, msg);
      mismatches++;
   endtask

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Long receiver hold-off, started by a toggle of hold_go.
   always @(posedge clock) begin
      if (hold_go != hold_seen) begin
         hold_seen <= hold_go;
         hold_left <= 400;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Result side: check each beat and decide the next ready.
   always @(posedge clock) begin
      string msg;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            msg = board.check_result('{rsp_tuser, rsp_tdata[11:0], rsp_tdata[32:12],
                                       rsp_tdata[53:33], rsp_tdata[74:54], rsp_tlast});
            if (msg != "") report(msg);
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
      end
   end

   // Offers one beat, with random idle cycles ahead of it, and waits for acceptance.
   task send(input logic [3:0] user, input logic [79:0] data);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= user;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_beat(user, data);
      beats_sent++;
   endtask

   task send_corner(input int slot, input int total, input logic [21:0] pn,
                    input logic up, input logic [21:0] un, input logic np,
                    input logic [21:0] nn);
      send({2'd0, OP_CORNER}, {7'd0, nn, np, un, up, pn, 3'(total), 2'(slot)});
   endtask

   task send_attr(input logic [1:0] kind, input int times);
      for (int i = 0; i < times; i++) send({kind, OP_ATTR}, '0);
   endtask

   // Pauses the sender until every expected record has come, then lets the block settle.
   task drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.expected_recs.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Mostly a small in-range number so keys repeat; now and then an out-of-range one.
   function logic [21:0] pick_number(logic [NUM_BITS-1:0] count);
      int r;
      r = $urandom_range(99);
      if (r < 3) return '0;
      if (r < 6) return 22'(count + 1);
      if (r < 8) return 22'($urandom);
      if (count == 0) return 22'd1;
      return 22'($urandom_range(1, (count < 24) ? count : 24));
   endfunction

   // One random item: usually a whole face, sometimes noise or a broken face.
   task random_item;
      int  r, total;
      r = $urandom_range(99);
      if (r < 8) begin
         send_attr(2'($urandom_range(3)), 1);
      end else if (r < 10) begin
         send({2'd0, OP_GROUP}, 80'($urandom));
      end else if (r < 11) begin
         send({2'($urandom), 2'd3}, 80'({$urandom, $urandom, $urandom}));
      end else if (r < 15) begin
         send({2'($urandom), OP_CORNER}, {7'd0, 9'($urandom), $urandom, $urandom});
      end else begin
         total = ($urandom_range(1)) ? 4 : 3;
         for (int s = 0; s < total; s++) begin
            if ($urandom_range(99) >= 3)
               send_corner(s, total, pick_number(board.pos_count), 1'($urandom),
                           pick_number(board.uv_count), 1'($urandom),
                           pick_number(board.normal_count));
         end
      end
   endtask

   initial begin
      int idle_mix [4];
      int stall_mix [4];
      idle_mix = '{0, 79, 0, 25};
      stall_mix = '{0, 0, 79, 25};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: corners before any declaration, ignored codes, then basic faces.
      send_corner(0, 3, 22'd1, 1'b0, '0, 1'b0, '0);
      send({2'd3, OP_ATTR}, '0);
      send({2'd0, 2'd3}, '1);
      send_attr(ATTR_POS, 8);
      send_attr(ATTR_UV, 4);
      send_attr(ATTR_NORMAL, 4);
      for (int rep = 0; rep < 2; rep++)
         for (int s = 0; s < 3; s++) send_corner(s, 3, 22'(s + 1), 1'b0, '0, 1'b0, '0);
      send_corner(0, 4, 22'd8, 1'b1, 22'd4, 1'b1, 22'd4);
      send_corner(1, 4, 22'd1, 1'b1, 22'd1, 1'b0, '1);
      send_corner(2, 4, 22'd2, 1'b0, '1, 1'b1, 22'd1);
      send_corner(3, 4, 22'd8, 1'b1, 22'd4, 1'b1, 22'd4);
      // Bad corners: missing, too large, bad uv, all ones.
      send_corner(0, 3, 22'd0, 1'b0, '0, 1'b0, '0);
      send_corner(0, 3, 22'd9, 1'b0, '0, 1'b0, '0);
      send_corner(1, 3, 22'd1, 1'b1, 22'd5, 1'b0, '0);
      send_corner(2, 3, '1, 1'b1, '1, 1'b1, '1);
      // Bad shapes: too many corners, too few, slot beyond the total.
      send_corner(0, 5, 22'd1, 1'b0, '0, 1'b0, '0);
      send_corner(0, 2, 22'd1, 1'b0, '0, 1'b0, '0);
      send_corner(3, 3, 22'd1, 1'b0, '0, 1'b0, '0);
      // A face with a missing corner, then one cut by a group.
      send_corner(0, 3, 22'd4, 1'b0, '0, 1'b0, '0);
      send_corner(2, 3, 22'd5, 1'b0, '0, 1'b0, '0);
      send_corner(0, 3, 22'd6, 1'b0, '0, 1'b0, '0);
      send({2'd0, OP_GROUP}, '0);
      send_corner(1, 3, 22'd7, 1'b0, '0, 1'b0, '0);
      send_corner(2, 3, 22'd8, 1'b0, '0, 1'b0, '0);
      drain();

      // Random phases with different idle and stall mixes.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle = idle_mix[ph];
         stall_pct = stall_mix[ph];
         if (ph == 0) hold_go <= ~hold_go;
         for (int start = beats_sent; beats_sent < start + 70; ) random_item();
         drain();
      end

      // Nothing left in flight: last checks and verdict.
      while (board.expected_recs.size() != 0) begin
         report("expected record never arrived");
         void'(board.expected_recs.pop_front());
      end
      $display("Sent %0d beats: directed face and corner cases, then random faces and noise",
               beats_sent);
      $display("under four idle mixes and a long hold-off; %0d records checked, %0d full.",
               board.checked, board.full_seen);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
`default_nettype wire
